FILE: hdl/wotd_pkg.sv
// Shared constants, codes and types of the windowed over-threshold detector.
// No dependencies; wotd_if, the top level and the bench refer to it.
package wotd_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int CHANNELS       = 4;
    localparam int CHAN_BITS      = 2;
    localparam int WINDOW_DEFAULT = 16;

    localparam int THR_BITS       = 13;
    localparam int NEED_BITS      = 5;
    localparam int OVER_BITS      = 5;
    localparam int NUM_THR        = 4;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    // register indexes of the write port
    localparam logic [CFG_INDEX_BITS-1:0] REG_THR_CH0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THR_CH3 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDED  = 3'd4;

    localparam logic [THR_BITS-1:0]  THR_RESET  = 13'd4095;
    localparam logic [NEED_BITS-1:0] NEED_RESET = 5'd8;

    // request commands
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_OLD,
        ST_UPDATE,
        ST_SCAN,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/wotd_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on wotd_pkg for the field widths.
interface wotd_item_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic [wotd_pkg::CHAN_BITS-1:0]     channel;
    logic [wotd_pkg::SAMPLE_BITS-1:0]   sample;

    modport source (output valid, output command, output channel, output sample,
                    input ready);
    modport sink   (input valid, input command, input channel, input sample,
                    output ready);
endinterface

interface wotd_result_if;
    logic                               valid;
    logic                               ready;
    logic                               hit;
    logic [wotd_pkg::OVER_BITS-1:0]     over_count;
    logic [wotd_pkg::SAMPLE_BITS-1:0]   window_avg;
    logic [wotd_pkg::SAMPLE_BITS-1:0]   window_max;

    modport source (output valid, output hit, output over_count, output window_avg,
                    output window_max, input ready);
    modport sink   (input valid, input hit, input over_count, input window_avg,
                    input window_max, output ready);
endinterface

FILE: hdl/wotd_alu.sv
// Shared subtractor: a - b with borrow, serves the max compare and the divide step.
// No package dependencies.
module wotd_alu #(
    parameter int W = 13
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         borrow
);

    logic [W:0] full_diff;

    assign full_diff = {1'b0, a} - {1'b0, b};
    assign diff      = full_diff[W-1:0];
    assign borrow    = full_diff[W];

endmodule

FILE: hdl/wotd_ring.sv
// Sample ring memory: one write port, one read port with registered data.
// No package dependencies.
module wotd_ring #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 12
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/windowed_over_threshold_detector_top.sv
// Top level of the windowed over-threshold detector: sequencer, channel state,
// configuration registers and result register. Uses wotd_pkg, wotd_if,
// wotd_alu and wotd_ring.
//
// Each request either pushes a sample into its channel's sliding window or
// clears that window, and every request yields exactly one result: hit,
// over_count, window_avg and window_max. The block works on one request at a
// time. A push goes through the read-old, update, scan, divide and finish
// steps. The scan walks the single read port of the sample ring one entry
// per cycle, and the shared subtractor first serves the max compare and then
// one restoring-divide step per cycle for the average. A clear goes straight
// from acceptance to the finish step. The block takes the next request once
// it is back in idle after a result is loaded. The result sits in an output
// register, so a new request is accepted while the previous result still
// waits to be taken; a finished result is held in the last step until the
// output register frees up. The ring needs no clearing after reset: only
// entries written since the channel last emptied are ever read, which the
// fill count tracks. Write configuration only while the block is idle.
module windowed_over_threshold_detector_top #(
    parameter int WINDOW = wotd_pkg::WINDOW_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    wotd_item_if.sink                             item,
    wotd_result_if.source                         result,
    input  logic                                  cfg_write,
    input  logic [wotd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wotd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int SB   = wotd_pkg::SAMPLE_BITS;
    localparam int CB   = wotd_pkg::CHAN_BITS;
    localparam int CH   = wotd_pkg::CHANNELS;
    localparam int IW   = $clog2(WINDOW);           // ring index within a channel
    localparam int CW   = $clog2(WINDOW + 1);       // fill and over counts
    localparam int TW   = SB + CW;                  // running window sum
    localparam int SW   = $clog2(TW);               // divide step counter
    localparam int AW   = CB + IW;                  // ring address
    localparam int UW   = (SB > CW + 1) ? SB : CW + 1;
    localparam int NW   = (CW > wotd_pkg::NEED_BITS) ? CW : wotd_pkg::NEED_BITS;

    localparam logic [CW-1:0] WIN_C     = CW'(WINDOW);
    localparam logic [IW-1:0] IDX_LAST  = IW'(WINDOW - 1);
    localparam logic [SW-1:0] STEP_LAST = SW'(TW - 1);

    // ---------------------------------------------------------------
    // State and storage
    // ---------------------------------------------------------------
    wotd_pkg::state_t state_reg, state_next;

    // per-channel window bookkeeping
    logic [IW-1:0] wpos_reg  [CH];
    logic [IW-1:0] wpos_next [CH];
    logic [CW-1:0] fill_reg  [CH];
    logic [CW-1:0] fill_next [CH];
    logic [TW-1:0] total_reg [CH];
    logic [TW-1:0] total_next[CH];
    logic [CW-1:0] above_reg [CH];
    logic [CW-1:0] above_next[CH];

    // configuration
    logic [wotd_pkg::THR_BITS-1:0]  thr_reg [wotd_pkg::NUM_THR];
    logic [wotd_pkg::NEED_BITS-1:0] need_reg;

    // working registers of the request in flight
    logic [CB-1:0] ch_reg,   ch_next;
    logic [SB-1:0] smp_reg,  smp_next;
    logic          zero_reg, zero_next;     // result is all zeros (clear, bad channel)
    logic [CW-1:0] k_reg,    k_next;        // scan read index
    logic          rdv_reg,  rdv_next;      // scan read data arrives this cycle
    logic [SB-1:0] mx_reg,   mx_next;
    logic [TW-1:0] dvd_reg,  dvd_next;      // dividend, quotient shifts in from the bottom
    logic [CW-1:0] rem_reg,  rem_next;
    logic [SW-1:0] step_reg, step_next;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic                           hit_reg,  hit_next;
    logic [wotd_pkg::OVER_BITS-1:0] over_reg, over_next;
    logic [SB-1:0]                  avg_reg,  avg_next;
    logic [SB-1:0]                  max_reg,  max_next;

    // ring and shared subtractor hookup
    logic          ring_we, ring_re;
    logic [AW-1:0] ring_waddr, ring_raddr;
    logic [SB-1:0] ring_wdata, ring_rdata;
    logic [UW-1:0] alu_a, alu_b, alu_diff;
    logic          alu_borrow;

    // ---------------------------------------------------------------
    // Shared helpers
    // ---------------------------------------------------------------
    logic                 item_accept;
    logic                 item_chan_ok;
    logic                 out_free;
    logic                 scan_done;
    logic [CW:0]          div_shift;
    logic                 full_now;
    logic                 hit_now;
    logic [wotd_pkg::THR_BITS-1:0] thr_cur;

    assign item.ready   = (state_reg == wotd_pkg::ST_IDLE);
    assign item_accept  = item.valid && item.ready;
    assign item_chan_ok = (int'(item.channel) < CH);
    assign out_free     = !out_valid_reg || result.ready;
    assign scan_done    = (k_reg == fill_reg[ch_reg]);
    assign div_shift    = {rem_reg, dvd_reg[TW-1]};
    assign full_now     = (fill_reg[ch_reg] == WIN_C);
    assign hit_now      = full_now && (NW'(above_reg[ch_reg]) >= NW'(need_reg));
    assign thr_cur      = thr_reg[ch_reg];

    assign result.valid      = out_valid_reg;
    assign result.hit        = hit_reg;
    assign result.over_count = over_reg;
    assign result.window_avg = avg_reg;
    assign result.window_max = max_reg;

    wotd_ring #(
        .ADDR_BITS (AW),
        .DATA_BITS (SB)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    wotd_alu #(
        .W (UW)
    ) u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wotd_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    // clears and bad channels answer right away
                    if (item.command == wotd_pkg::CMD_CLEAR || !item_chan_ok)
                    begin
                        state_next = wotd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = wotd_pkg::ST_READ_OLD;
                    end
                end
            end
            wotd_pkg::ST_READ_OLD: state_next = wotd_pkg::ST_UPDATE;
            wotd_pkg::ST_UPDATE:   state_next = wotd_pkg::ST_SCAN;
            wotd_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = wotd_pkg::ST_DIV;
                end
            end
            wotd_pkg::ST_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = wotd_pkg::ST_FINISH;
                end
            end
            wotd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = wotd_pkg::ST_IDLE;
                end
            end
            default: state_next = wotd_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: datapath control and next values
    // ---------------------------------------------------------------
    always_comb
    begin
        logic          old_over;
        logic          new_over;
        logic [TW-1:0] total_tmp;
        logic [CW-1:0] above_tmp;

        old_over  = 1'b0;
        new_over  = 1'b0;
        total_tmp = '0;
        above_tmp = '0;

        ring_we    = 1'b0;
        ring_waddr = '0;
        ring_wdata = smp_reg;
        ring_re    = 1'b0;
        ring_raddr = '0;
        alu_a      = '0;
        alu_b      = '0;

        wpos_next  = wpos_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        above_next = above_reg;

        ch_next   = ch_reg;
        smp_next  = smp_reg;
        zero_next = zero_reg;
        k_next    = k_reg;
        rdv_next  = 1'b0;
        mx_next   = mx_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;

        // drop the result once taken
        out_valid_next = out_valid_reg && !result.ready;
        hit_next       = hit_reg;
        over_next      = over_reg;
        avg_next       = avg_reg;
        max_next       = max_reg;

        unique case (state_reg)
            wotd_pkg::ST_IDLE:
            begin
                if (item_accept)
                begin
                    ch_next   = item.channel;
                    smp_next  = item.sample;
                    zero_next = (item.command == wotd_pkg::CMD_CLEAR) || !item_chan_ok;
                    if (item.command == wotd_pkg::CMD_CLEAR && item_chan_ok)
                    begin
                        wpos_next[item.channel]  = '0;
                        fill_next[item.channel]  = '0;
                        total_next[item.channel] = '0;
                        above_next[item.channel] = '0;
                    end
                end
            end

            wotd_pkg::ST_READ_OLD:
            begin
                // fetch the oldest sample at the write position
                ring_re    = 1'b1;
                ring_raddr = {ch_reg, wpos_reg[ch_reg]};
            end

            wotd_pkg::ST_UPDATE:
            begin
                total_tmp = total_reg[ch_reg];
                above_tmp = above_reg[ch_reg];
                if (full_now)
                begin
                    // retire the oldest sample against the threshold in force now
                    old_over  = ({1'b0, ring_rdata} > thr_cur);
                    total_tmp = total_tmp - TW'(ring_rdata);
                    if (old_over && above_tmp != '0)
                    begin
                        above_tmp = above_tmp - 1'b1;
                    end
                end
                else
                begin
                    fill_next[ch_reg] = fill_reg[ch_reg] + 1'b1;
                end

                new_over = ({1'b0, smp_reg} > thr_cur);
                if (new_over && above_tmp < WIN_C)
                begin
                    above_tmp = above_tmp + 1'b1;
                end

                ring_we    = 1'b1;
                ring_waddr = {ch_reg, wpos_reg[ch_reg]};
                wpos_next[ch_reg]  = (wpos_reg[ch_reg] == IDX_LAST) ? '0
                                                                    : wpos_reg[ch_reg] + 1'b1;
                total_next[ch_reg] = total_tmp + TW'(smp_reg);
                above_next[ch_reg] = above_tmp;

                k_next  = '0;
                mx_next = '0;
            end

            wotd_pkg::ST_SCAN:
            begin
                if (!scan_done)
                begin
                    ring_re    = 1'b1;
                    ring_raddr = {ch_reg, k_reg[IW-1:0]};
                    k_next     = k_reg + 1'b1;
                    rdv_next   = 1'b1;
                end
                if (rdv_reg)
                begin
                    // borrow on mx - v means v is larger
                    alu_a = UW'(mx_reg);
                    alu_b = UW'(ring_rdata);
                    if (alu_borrow)
                    begin
                        mx_next = ring_rdata;
                    end
                end
                if (scan_done)
                begin
                    dvd_next  = total_reg[ch_reg];
                    rem_next  = '0;
                    step_next = '0;
                end
            end

            wotd_pkg::ST_DIV:
            begin
                // one restoring step per cycle, fill count is never zero here
                alu_a = UW'(div_shift);
                alu_b = UW'(fill_reg[ch_reg]);
                if (alu_borrow)
                begin
                    rem_next = div_shift[CW-1:0];
                end
                else
                begin
                    rem_next = alu_diff[CW-1:0];
                end
                dvd_next  = {dvd_reg[TW-2:0], !alu_borrow};
                step_next = step_reg + 1'b1;
            end

            wotd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        hit_next  = 1'b0;
                        over_next = '0;
                        avg_next  = '0;
                        max_next  = '0;
                    end
                    else
                    begin
                        hit_next  = hit_now;
                        over_next = wotd_pkg::OVER_BITS'(above_reg[ch_reg]);
                        avg_next  = dvd_reg[SB-1:0];
                        max_next  = mx_reg;
                        // a hit empties the window after the result is formed
                        if (hit_now)
                        begin
                            wpos_next[ch_reg]  = '0;
                            fill_next[ch_reg]  = '0;
                            total_next[ch_reg] = '0;
                            above_next[ch_reg] = '0;
                        end
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wotd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CH; c++)
            begin
                wpos_reg[c]  <= '0;
                fill_reg[c]  <= '0;
                total_reg[c] <= '0;
                above_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            wpos_reg      <= wpos_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            above_reg     <= above_next;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers; writes past the last index are ignored
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < wotd_pkg::NUM_THR; t++)
            begin
                thr_reg[t] <= wotd_pkg::THR_RESET;
            end
            need_reg <= wotd_pkg::NEED_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index <= wotd_pkg::REG_THR_CH3)
            begin
                thr_reg[cfg_index[1:0]] <= cfg_data[wotd_pkg::THR_BITS-1:0];
            end
            else if (cfg_index == wotd_pkg::REG_NEEDED)
            begin
                need_reg <= cfg_data[wotd_pkg::NEED_BITS-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Working and result payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        smp_reg  <= smp_next;
        zero_reg <= zero_next;
        k_reg    <= k_next;
        rdv_reg  <= rdv_next;
        mx_reg   <= mx_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        hit_reg  <= hit_next;
        over_reg <= over_next;
        avg_reg  <= avg_next;
        max_reg  <= max_next;
    end

endmodule

FILE: test/tb.sv
// Self-checking bench for the windowed over-threshold detector: drives requests,
// predicts each result from its own per-channel window copy and compares them.
// Depends on wotd_pkg, wotd_if and windowed_over_threshold_detector_top.
module tb;
    import wotd_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int WIN          = WINDOW_DEFAULT;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int THR_MAX      = (1 << THR_BITS) - 1;
    localparam int NEED_MAX     = (1 << NEED_BITS) - 1;
    localparam int PHASE_REQS   = 156;
    localparam int END_WAIT     = 120;
    localparam int MAX_PRINTED  = 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LAST_INDEX   = (1 << CFG_INDEX_BITS) - 1;

    typedef struct packed {
        logic                   command;
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
    } window_req_t;

    typedef struct packed {
        logic                   hit;
        logic [OVER_BITS-1:0]   over_count;
        logic [SAMPLE_BITS-1:0] window_avg;
        logic [SAMPLE_BITS-1:0] window_max;
    } window_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    wotd_item_if   item_ch();
    wotd_result_if result_ch();

    windowed_over_threshold_detector_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Window copy kept by the bench, one entry per channel.
    logic [SAMPLE_BITS-1:0]   ring_copy [CHANNELS][WIN];
    logic [$clog2(WIN)-1:0]   wr_pos    [CHANNELS];
    logic [OVER_BITS-1:0]     fill      [CHANNELS];
    logic [15:0]              win_total [CHANNELS];
    logic [OVER_BITS-1:0]     above     [CHANNELS];
    logic [THR_BITS-1:0]      thr_reg   [NUM_THR];
    logic [NEED_BITS-1:0]     need_reg;

    window_req_t    pending_requests[$];
    window_result_t expected_results[$];
    window_req_t    on_wire;

    logic allow_gaps;
    int   send_gap;
    int   stall_left;
    int   mismatch_count = 0;
    int   accepted_count = 0;
    int   clear_count    = 0;
    int   hit_count      = 0;
    int   result_count   = 0;
    int   cfg_count      = 0;

    // Clock: period of 4 time units.
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s", $time, result_count, what);
        mismatch_count++;
    endtask

    function automatic void empty_window(input int ch);
        for (int k = 0; k < WIN; k++)
            ring_copy[ch][k] = '0;
        wr_pos[ch]    = '0;
        fill[ch]      = '0;
        win_total[ch] = '0;
        above[ch]     = '0;
    endfunction

    // Apply one request to the window copy and return the result it must produce.
    function automatic window_result_t advance_window(input window_req_t req);
        window_result_t         res;
        logic [SAMPLE_BITS-1:0] oldest;
        logic [SAMPLE_BITS-1:0] peak;
        logic [THR_BITS-1:0]    thr;
        logic [15:0]            quotient;
        int                     ch;

        res = '0;
        ch  = int'(req.channel);
        if (req.command == CMD_CLEAR)
        begin
            empty_window(ch);
            clear_count++;
            return res;
        end

        thr = thr_reg[ch];
        // Drop the oldest sample once the window is full; it is judged by the
        // threshold in force now, and the count never goes below zero.
        if (fill[ch] >= WIN)
        begin
            oldest        = ring_copy[ch][wr_pos[ch]];
            win_total[ch] = win_total[ch] - oldest;
            if (oldest > thr && above[ch] != 0)
                above[ch] = above[ch] - 1'b1;
        end
        else
            fill[ch] = fill[ch] + 1'b1;

        ring_copy[ch][wr_pos[ch]] = req.sample;
        wr_pos[ch]    = wr_pos[ch] + 1'b1;
        win_total[ch] = win_total[ch] + req.sample;
        // Saturate the count at the window size; threshold changes can push it up.
        if (req.sample > thr && above[ch] < WIN)
            above[ch] = above[ch] + 1'b1;

        peak = '0;
        for (int k = 0; k < fill[ch]; k++)
            if (ring_copy[ch][k] > peak)
                peak = ring_copy[ch][k];
        quotient = win_total[ch] / fill[ch];

        res.hit        = (fill[ch] >= WIN) && (above[ch] >= need_reg);
        res.over_count = above[ch];
        res.window_avg = quotient[SAMPLE_BITS-1:0];
        res.window_max = peak;

        // A hit reports the window as it stood, then empties it.
        if (res.hit)
        begin
            empty_window(ch);
            hit_count++;
        end
        return res;
    endfunction

    // Driver: present pending requests, insert random gaps between them and
    // predict each request at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.command <= CMD_PUSH;
            item_ch.channel <= '0;
            item_ch.sample  <= '0;
            send_gap = 0;
            for (int c = 0; c < CHANNELS; c++)
                empty_window(c);
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_results.push_back(advance_window(on_wire));
                accepted_count++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (allow_gaps && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(1, 8) - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    on_wire = pending_requests.pop_front();
                    item_ch.valid   <= 1'b1;
                    item_ch.command <= on_wire.command;
                    item_ch.channel <= on_wire.channel;
                    item_ch.sample  <= on_wire.sample;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: stall the result side in random bursts and check every result
    // taken against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        window_result_t want;

        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                    report_mismatch("result with no request waiting for it");
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.hit !== want.hit)
                        report_mismatch($sformatf("hit %0b, want %0b",
                                                  result_ch.hit, want.hit));
                    if (result_ch.over_count !== want.over_count)
                        report_mismatch($sformatf("over_count %0d, want %0d",
                                                  result_ch.over_count, want.over_count));
                    if (result_ch.window_avg !== want.window_avg)
                        report_mismatch($sformatf("window_avg %0d, want %0d",
                                                  result_ch.window_avg, want.window_avg));
                    if (result_ch.window_max !== want.window_max)
                        report_mismatch($sformatf("window_max %0d, want %0d",
                                                  result_ch.window_max, want.window_max));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (allow_gaps && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Write one register; only called while the block is idle, so the bench
    // copy of the settings can follow at once.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx <= REG_THR_CH3)
            thr_reg[2'(idx - REG_THR_CH0)] = data[THR_BITS-1:0];
        else if (idx == REG_NEEDED)
            need_reg = data[NEED_BITS-1:0];
        cfg_count++;
    endtask

    // Write all four thresholds, the needed count (with junk in the unused
    // upper data bits) and one index past the last register, which must do nothing.
    task automatic configure(input int t0, input int t1, input int t2, input int t3,
                             input int need);
        logic [CFG_DATA_BITS-1:0] data;

        write_reg(REG_THR_CH0,                         CFG_DATA_BITS'(t0));
        write_reg(CFG_INDEX_BITS'(REG_THR_CH0 + 1),    CFG_DATA_BITS'(t1));
        write_reg(CFG_INDEX_BITS'(REG_THR_CH0 + 2),    CFG_DATA_BITS'(t2));
        write_reg(REG_THR_CH3,                         CFG_DATA_BITS'(t3));
        data = CFG_DATA_BITS'($urandom);
        data[NEED_BITS-1:0] = NEED_BITS'(need);
        write_reg(REG_NEEDED, data);
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_NEEDED + 1, LAST_INDEX)),
                  CFG_DATA_BITS'($urandom));
    endtask

    task automatic queue_req(input logic cmd, input int ch, input int smp);
        window_req_t req;

        req.command = cmd;
        req.channel = CHAN_BITS'(ch);
        req.sample  = SAMPLE_BITS'(smp);
        pending_requests.push_back(req);
    endtask

    // Samples cluster at the extremes and right around the channel threshold,
    // so the strict above test is hit from both sides.
    function automatic int pick_sample(input logic [THR_BITS-1:0] thr);
        int sel;
        int v;

        sel = $urandom_range(0, 99);
        if (sel < 12)
            return 0;
        if (sel < 24)
            return SAMPLE_MAX;
        if (sel < 64)
        begin
            v = int'(thr) - 8 + int'($urandom_range(0, 16));
            if (v < 0)
                v = 0;
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            return v;
        end
        return $urandom_range(0, SAMPLE_MAX);
    endfunction

    // Random requests: mostly pushes, often in runs on one channel so windows
    // fill and hit; a few clears break the sequences.
    task automatic queue_random(input int count, input int clear_pct);
        int left;
        int run;
        int ch;

        left = count;
        while (left > 0)
        begin
            ch  = $urandom_range(0, CHANNELS - 1);
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : 1;
            if (run > left)
                run = left;
            repeat (run)
                queue_req(($urandom_range(0, 99) < clear_pct) ? CMD_CLEAR : CMD_PUSH,
                          ch, pick_sample(thr_reg[ch]));
            left -= run;
        end
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic drain_block();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || item_ch.valid
               || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic int random_need();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, NEED_MAX);
        return $urandom_range(1, WIN);
    endfunction

    initial
    begin
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        allow_gaps      = 1'b1;
        for (int c = 0; c < NUM_THR; c++)
            thr_reg[c] = THR_RESET;
        need_reg = NEED_RESET;

        // Hold reset, then release it away from the active edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: a sample equal to the threshold must not count,
        // clear a live window and an empty one.
        queue_req(CMD_PUSH,  0, SAMPLE_MAX);
        queue_req(CMD_PUSH,  0, 0);
        queue_req(CMD_PUSH,  1, 'hAAA);
        queue_req(CMD_PUSH,  1, 'h555);
        queue_req(CMD_CLEAR, 0, SAMPLE_MAX);
        queue_req(CMD_CLEAR, 2, 'h5A5);
        queue_req(CMD_PUSH,  3, SAMPLE_MAX);
        drain_block();

        // Threshold extremes, needed count of one; write every spare index too.
        configure(0, THR_MAX, 0, SAMPLE_MAX, 1);
        for (int idx = REG_NEEDED + 1; idx <= LAST_INDEX; idx++)
            write_reg(CFG_INDEX_BITS'(idx), CFG_DATA_BITS'($urandom));
        // Fill channel 2 to a hit, which must empty it; the next push starts over.
        repeat (WIN) queue_req(CMD_PUSH, 2, 1);
        queue_req(CMD_PUSH,  2, SAMPLE_MAX);
        queue_req(CMD_CLEAR, 1, 0);
        drain_block();

        // Zero thresholds and a needed count that cannot be met: counts climb to the top.
        configure(0, 0, 0, 0, NEED_MAX);
        queue_random(PHASE_REQS, 3);
        drain_block();

        // Raise thresholds under full windows: old samples no longer leave the
        // count while new high ones still add, so it saturates.
        configure(4000, 4000, 4000, 4000, NEED_MAX);
        queue_random(PHASE_REQS, 3);
        drain_block();

        // Top thresholds, needed count zero: every push on a full window hits.
        configure(THR_MAX, THR_MAX, THR_MAX, THR_MAX, 0);
        queue_random(PHASE_REQS, 3);
        drain_block();

        configure($urandom_range(1500, 2500), $urandom_range(1500, 2500),
                  $urandom_range(1500, 2500), $urandom_range(1500, 2500),
                  $urandom_range(1, WIN));
        queue_random(PHASE_REQS, 5);
        drain_block();

        configure($urandom_range(0, THR_MAX), $urandom_range(0, THR_MAX),
                  $urandom_range(0, THR_MAX), $urandom_range(0, THR_MAX), WIN);
        queue_random(PHASE_REQS, 3);
        drain_block();

        // Random settings; the last phase runs with no gaps or stalls.
        for (int p = 0; p < 3; p++)
        begin
            if (p == 2)
                allow_gaps = 1'b0;
            configure($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                      $urandom_range(0, THR_MAX), $urandom_range(0, SAMPLE_MAX),
                      random_need());
            queue_random(PHASE_REQS, 4);
            drain_block();
        end

        // Leave room for any stray result to show up.
        repeat (END_WAIT) @(negedge clk);

        $display("Checked %0d results for %0d requests (%0d clears, %0d hits)",
                 result_count, accepted_count, clear_count, hit_count);
        $display("across %0d register writes, with and without gaps and stalls",
                 cfg_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop if the block hangs.
    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("Timeout with %0d results still awaited", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
